>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// word types and command codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int FW = 32;

  typedef enum logic [2:0] {
    CMD_NORM = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_CMP  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]           command;
    logic signed [FW-1:0] a_num;
    logic signed [FW-1:0] a_den;
    logic signed [FW-1:0] b_num;
    logic signed [FW-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [FW-1:0] res_num;
    logic [FW-1:0]        res_den;
    logic                 zero_den_error;
    logic                 overflow;
    logic                 is_equal;
    logic                 is_less;
    logic                 is_greater;
  } out_word_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact normalize, add, subtract, multiply, divide and compare of signed fractions,
// reduced by the euclidean gcd
// ----------------------------------------------------------------------------
// One word at a time. A command forms four products on the single multiplier,
// then one pass of the shared bit-serial divider per euclid step (up to about
// 93 steps for 64-bit values), then two more divider passes for the reduction,
// then a format step. Error and unused commands go from idle straight to output.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_word_t out_data
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_GCD, S_GCDW,
    S_RN, S_RNW, S_RD, S_RDW, S_FMT, S_OUT
  } state_t;

  state_t      state_r;
  logic [2:0]  cmd_r;
  logic [W-1:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic        an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [63:0] p0_r, p1_r;
  logic        p0_s_r, p1_s_r;
  logic [63:0] num_r, den_r, x_r, y_r, rn_r;
  logic        nneg_r, dneg_r;
  logic [2:0]  mcnt_r;
  out_word_t   out_r;
  logic        ovf;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [W-1:0] mul_a, mul_b;
  logic [63:0]  prod;

  function automatic logic [W-1:0] magof(input logic [FW-1:0] v);
    logic [W-1:0] t;
    t = v[W-1:0];
    return t[W-1] ? (~t + 1'b1) : t;
  endfunction

  // single shared multiplier
  always_comb begin
    case (mcnt_r)
      3'd0:    begin mul_a = an_m_r; mul_b = bd_m_r; end
      3'd1:    begin mul_a = bn_m_r; mul_b = ad_m_r; end
      3'd3:    begin mul_a = an_m_r; mul_b = bn_m_r; end
      default: begin mul_a = ad_m_r; mul_b = bd_m_r; end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic        err;
  logic        fneg;
  logic [63:0] lim;
  logic [63:0] wmax;

  always_comb begin
    lim  = 64'd1 << (W - 1);
    wmax = (64'd1 << W) - 64'd1;
    fneg = (num_r != 64'd0) && (nneg_r != dneg_r);
    ovf  = (x_r > wmax) || (fneg ? rn_r > lim : rn_r >= lim);
    dreq.start    = 1'b0;
    dreq.dividend = x_r;
    dreq.divisor  = y_r;
    case (state_r)
      S_GCD: dreq.start = (y_r != 64'd0);
      S_RN:  begin dreq.start = 1'b1; dreq.dividend = num_r; dreq.divisor = x_r; end
      S_RD:  begin dreq.start = 1'b1; dreq.dividend = den_r; end
      default: ;
    endcase
    err = (in_data.a_den[W-1:0] == '0) ||
          (in_data.command != CMD_NORM && in_data.b_den[W-1:0] == '0) ||
          (in_data.command == CMD_DIV && in_data.b_num[W-1:0] == '0);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mcnt_r  <= 3'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_data.command;
            an_m_r <= magof(in_data.a_num); an_s_r <= in_data.a_num[W-1];
            ad_m_r <= magof(in_data.a_den); ad_s_r <= in_data.a_den[W-1];
            bn_m_r <= magof(in_data.b_num); bn_s_r <= in_data.b_num[W-1];
            bd_m_r <= magof(in_data.b_den); bd_s_r <= in_data.b_den[W-1];
            mcnt_r <= 3'd0;
            if (in_data.command > CMD_CMP) begin
              out_r   <= '{res_den: 32'd1, default: '0};
              state_r <= S_OUT;
            end else if (err) begin
              out_r   <= '{res_num: 32'sd1, res_den: 32'd1, zero_den_error: 1'b1,
                          default: '0};
              state_r <= S_OUT;
            end else begin
              out_r   <= '0;
              state_r <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          p0_r <= prod; p0_s_r <= an_s_r ^ bd_s_r;
          mcnt_r <= 3'd1; state_r <= S_MUL1;
        end
        S_MUL1: begin
          p1_r <= prod; p1_s_r <= bn_s_r ^ ad_s_r;
          mcnt_r <= 3'd2; state_r <= S_MUL2;
        end
        S_MUL2: begin
          den_r <= prod; dneg_r <= ad_s_r ^ bd_s_r;
          mcnt_r <= 3'd3; state_r <= S_SUM;
        end
        S_SUM: begin
          case (cmd_r)
            CMD_NORM: begin
              num_r <= 64'(an_m_r); nneg_r <= an_s_r;
              den_r <= 64'(ad_m_r); dneg_r <= ad_s_r;
            end
            CMD_MUL: begin
              num_r <= prod; nneg_r <= an_s_r ^ bn_s_r;
            end
            CMD_DIV: begin
              num_r <= p0_r; nneg_r <= p0_s_r;
              den_r <= p1_r; dneg_r <= p1_s_r;
            end
            default: begin
              if (p0_s_r == (p1_s_r ^ (cmd_r != CMD_ADD))) begin
                num_r <= p0_r + p1_r; nneg_r <= p0_s_r;
              end else if (p0_r >= p1_r) begin
                num_r <= p0_r - p1_r; nneg_r <= p0_s_r;
              end else begin
                num_r <= p1_r - p0_r; nneg_r <= ~p0_s_r;
              end
            end
          endcase
          state_r <= S_GCD;
          x_r <= 64'd0; y_r <= 64'd0;
          mcnt_r <= 3'd3;
        end
        S_GCD: begin
          if (mcnt_r == 3'd3) begin
            x_r <= num_r; y_r <= den_r; mcnt_r <= 3'd4;
          end else if (y_r == 64'd0) begin
            state_r <= S_RN;
          end else begin
            state_r <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (drsp.done) begin
            x_r <= y_r; y_r <= drsp.rem; state_r <= S_GCD;
          end
        end
        S_RN: begin y_r <= x_r; state_r <= S_RNW; end
        S_RNW: begin
          if (drsp.done) begin rn_r <= drsp.quot; state_r <= S_RD; end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (drsp.done) begin x_r <= drsp.quot; state_r <= S_FMT; end
        end
        S_FMT: begin
          if (cmd_r == CMD_CMP) begin
            out_r.is_equal   <= (rn_r == 64'd0);
            out_r.is_less    <= (rn_r != 64'd0) && fneg;
            out_r.is_greater <= (rn_r != 64'd0) && !fneg;
          end
          if (ovf) begin
            out_r.overflow <= 1'b1;
            out_r.res_num  <= '0;
            out_r.res_den  <= 32'd1;
          end else begin
            out_r.res_num <= fneg ? 32'(64'd0 - rn_r) : 32'(rn_r);
            out_r.res_den <= 32'(x_r);
          end
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.res_den != 32'd0) else $error("zero denominator out");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.is_equal, out_data.is_less,
    out_data.is_greater}) <= 1) else $error("compare flags clash");
`endif

endmodule

>>> rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// 64-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  import rau_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, q_r[63]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      q_nxt    = req.dividend;
      rem_nxt  = 64'd0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

>>> dv/rational_arithmetic_unit_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_check
// watches both channels, works out the reduced fraction for every accepted
// input word and compares it field by field with the next output word
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rau_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rau_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import rau_pkg::*;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  out_word_t fraction_q[$];

  function automatic smag_t to_smag(logic [FW-1:0] v);
    smag_t r;
    r.neg = v[FW-1];
    r.mag = r.neg ? ((64'd1 << FW) - {32'd0, v}) : {32'd0, v};
    return r;
  endfunction

  function automatic smag_t mul_smag(smag_t x, smag_t y);
    smag_t r;
    r.neg = x.neg != y.neg;
    r.mag = x.mag * y.mag;
    return r;
  endfunction

  function automatic smag_t add_smag(smag_t x, smag_t y, logic sub);
    smag_t r;
    if (sub) y.neg = !y.neg;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_word_t reduce_fraction(in_word_t w);
    out_word_t r;
    smag_t an, ad, bn, bd, num, den;
    logic [63:0] g, rn, rd, lim;
    logic neg, err;
    an = to_smag(w.a_num);
    ad = to_smag(w.a_den);
    bn = to_smag(w.b_num);
    bd = to_smag(w.b_den);
    r = '0;
    if (w.command > CMD_CMP) begin
      r.res_den = 32'd1;
      return r;
    end
    err = (ad.mag == 0) || (w.command != CMD_NORM && bd.mag == 0) ||
          (w.command == CMD_DIV && bn.mag == 0);
    if (err) begin
      r.res_num = 32'sd1;
      r.res_den = 32'd1;
      r.zero_den_error = 1'b1;
      return r;
    end
    case (w.command)
      CMD_NORM: begin
        num = an;
        den = ad;
      end
      CMD_ADD: begin
        num = add_smag(mul_smag(an, bd), mul_smag(bn, ad), 1'b0);
        den = mul_smag(ad, bd);
      end
      CMD_MUL: begin
        num = mul_smag(an, bn);
        den = mul_smag(ad, bd);
      end
      CMD_DIV: begin
        num = mul_smag(an, bd);
        den = mul_smag(bn, ad);
      end
      default: begin
        num = add_smag(mul_smag(an, bd), mul_smag(bn, ad), 1'b1);
        den = mul_smag(ad, bd);
      end
    endcase
    neg = (num.mag != 0) && (num.neg != den.neg);
    g = euclid_gcd(num.mag, den.mag);
    rn = num.mag / g;
    rd = den.mag / g;
    if (w.command == CMD_CMP) begin
      r.is_equal = rn == 0;
      r.is_less = rn != 0 && neg;
      r.is_greater = rn != 0 && !neg;
    end
    lim = 64'd1 << (FW - 1);
    if (rd > 64'hFFFF_FFFF || (neg ? rn > lim : rn >= lim)) begin
      r.overflow = 1'b1;
      rn = 0;
      rd = 1;
      neg = 1'b0;
    end
    r.res_num = 32'(neg ? (64'd0 - rn) : rn);
    r.res_den = 32'(rd);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (fraction_q.size() == 0) begin
          $display("%0t unexpected word: expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = fraction_q.pop_front();
          if (want.res_num !== out_data.res_num || want.res_den !== out_data.res_den ||
              want.zero_den_error !== out_data.zero_den_error ||
              want.overflow !== out_data.overflow ||
              want.is_equal !== out_data.is_equal || want.is_less !== out_data.is_less ||
              want.is_greater !== out_data.is_greater) begin
            $display("%0t mismatch: expected %h actual %h", $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) fraction_q.push_back(reduce_fraction(in_data));
      pending <= fraction_q.size();
    end
  end

endmodule

>>> dv/rational_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// drives directed and random fraction words in bursts against a stalling
// receiver and reports the verdict of the checker
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  int fail_count;
  int pending;
  int stall_mode = 0;
  int stall_left = 0;

  always #4 clk = ~clk;

  rational_arithmetic_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rational_arithmetic_unit_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stall pattern: free, light or heavy stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 400);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 16);
      1: return -$urandom_range(0, 16);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return $urandom_range(0, 1000) - 500;
      4: return $urandom_range(0, 1) ? 32'h8000_0001 : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fraction(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
    in_word_t w;
    w.command = c;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    send_word(w);
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    in_word_t w;
    int burst;
    int sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fraction(CMD_NORM, 6, -4, 0, 0);
    send_fraction(CMD_NORM, 32'h8000_0000, 1, 0, 0);
    send_fraction(CMD_NORM, 32'h8000_0000, -1, 0, 0);
    send_fraction(CMD_NORM, 5, 0, 1, 1);
    send_fraction(CMD_NORM, 0, -7, 3, 0);
    send_fraction(CMD_ADD, 1, 2, 1, 3);
    send_fraction(CMD_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    send_fraction(CMD_ADD, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF);
    send_fraction(CMD_ADD, 1, 1, 1, 0);
    send_fraction(CMD_SUB, 3, 4, 3, 4);
    send_fraction(CMD_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
    send_fraction(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_fraction(CMD_MUL, 32'h8000_0000, -1, -1, 1);
    send_fraction(CMD_MUL, -2, 3, 3, -2);
    send_fraction(CMD_DIV, 1, 2, 0, 5);
    send_fraction(CMD_DIV, -3, 7, 9, -14);
    send_fraction(CMD_DIV, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_fraction(CMD_CMP, 1, 3, 2, 6);
    send_fraction(CMD_CMP, -1, 3, 1, 3);
    send_fraction(CMD_CMP, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
    send_fraction(CMD_CMP, 1, 1, 1, 0);
    send_fraction(3'd6, 1, 1, 1, 1);
    send_fraction(3'd7, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    idle_gap();

    sent = 0;
    while (sent < 1300) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        w.command = 3'($urandom_range(0, 15) == 0 ? $urandom_range(6, 7) :
                                                    $urandom_range(0, 5));
        w.a_num = rand_operand();
        w.a_den = rand_operand();
        w.b_num = rand_operand();
        w.b_den = rand_operand();
        send_word(w);
        sent++;
      end
      idle_gap();
      if (sent >= 650 && sent < 650 + burst) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_check.sv
dv/rational_arithmetic_unit_test.sv
